// ===== hdl/distance_keeping_drive_control_top_defines.svh =====
// ----------------------------------------------------------------------------
// Distance keeping drive control: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_KEEPING_DRIVE_CONTROL_TOP_DEFINES_SVH
`define DISTANCE_KEEPING_DRIVE_CONTROL_TOP_DEFINES_SVH

// Same-cycle implication
`define DKDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DKDC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dkdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance keeping drive control package
// Shared widths, codes, register indexes, reset values and record types.
// ----------------------------------------------------------------------------
`default_nettype none

package dkdc_pkg;

    localparam int DIST_W  = 16;
    localparam int DUTY_W  = 8;
    localparam int TICK_W  = 32;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 32;
    localparam int OUT_W   = 48;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_TARGET    = 4'd0;
    localparam logic [IDX_W-1:0] REG_DZ_LOW    = 4'd1;
    localparam logic [IDX_W-1:0] REG_DZ_HIGH   = 4'd2;
    localparam logic [IDX_W-1:0] REG_DUTY_FLR  = 4'd3;
    localparam logic [IDX_W-1:0] REG_DUTY_CEIL = 4'd4;
    localparam logic [IDX_W-1:0] REG_GAIN      = 4'd5;
    localparam logic [IDX_W-1:0] REG_TIMEOUT   = 4'd6;
    localparam logic [IDX_W-1:0] REG_STOP      = 4'd7;

    // Register reset values
    localparam logic [DIST_W-1:0] RST_TARGET    = 16'd250;
    localparam logic [DIST_W-1:0] RST_DZ_LOW    = 16'd230;
    localparam logic [DIST_W-1:0] RST_DZ_HIGH   = 16'd270;
    localparam logic [DUTY_W-1:0] RST_DUTY_FLR  = 8'd100;
    localparam logic [DUTY_W-1:0] RST_DUTY_CEIL = 8'd150;
    localparam logic [7:0]        RST_GAIN      = 8'd28;
    localparam logic [TICK_W-1:0] RST_TIMEOUT   = 32'd300;
    localparam logic [TICK_W-1:0] RST_STOP      = 32'd300;

    // Direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // Rounding offset for the Q20.4 product
    localparam logic [23:0] ROUND_HALF = 24'd8;

    typedef enum logic [1:0] {
        MODE_MOVE    = 2'd0,
        MODE_HOLD    = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_SEARCH  = 2'd3
    } mode_t;

    // What the tick tracker decided for one tick
    typedef enum logic [1:0] {
        KIND_FRESH  = 2'd0,
        KIND_STOP   = 2'd1,
        KIND_SEARCH = 2'd2
    } kind_t;

    typedef struct packed {
        logic [DIST_W-1:0] target;
        logic [DIST_W-1:0] dz_low;
        logic [DIST_W-1:0] dz_high;
        logic [DUTY_W-1:0] duty_floor;
        logic [DUTY_W-1:0] duty_ceiling;
        logic [7:0]        gain;
        logic [TICK_W-1:0] timeout_ticks;
        logic [TICK_W-1:0] stop_ticks;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [DIST_W-1:0] distance;
    } tick_t;

endpackage

`default_nettype wire

// ===== hdl/dkdc_cfg.sv =====
// ----------------------------------------------------------------------------
// Distance keeping drive control: configuration registers
// Write-only register file, decoded by index, with reset defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module dkdc_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [dkdc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [dkdc_pkg::CFG_W-1:0] cfg_wdata,
    output dkdc_pkg::cfg_t                  cfg
);
    import dkdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TARGET:    cfg_next.target        = cfg_wdata[DIST_W-1:0];
                REG_DZ_LOW:    cfg_next.dz_low        = cfg_wdata[DIST_W-1:0];
                REG_DZ_HIGH:   cfg_next.dz_high       = cfg_wdata[DIST_W-1:0];
                REG_DUTY_FLR:  cfg_next.duty_floor    = cfg_wdata[DUTY_W-1:0];
                REG_DUTY_CEIL: cfg_next.duty_ceiling  = cfg_wdata[DUTY_W-1:0];
                REG_GAIN:      cfg_next.gain          = cfg_wdata[7:0];
                REG_TIMEOUT:   cfg_next.timeout_ticks = cfg_wdata[TICK_W-1:0];
                REG_STOP:      cfg_next.stop_ticks    = cfg_wdata[TICK_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target        <= RST_TARGET;
            cfg_reg.dz_low        <= RST_DZ_LOW;
            cfg_reg.dz_high       <= RST_DZ_HIGH;
            cfg_reg.duty_floor    <= RST_DUTY_FLR;
            cfg_reg.duty_ceiling  <= RST_DUTY_CEIL;
            cfg_reg.gain          <= RST_GAIN;
            cfg_reg.timeout_ticks <= RST_TIMEOUT;
            cfg_reg.stop_ticks    <= RST_STOP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/dkdc_tracker.sv =====
// ----------------------------------------------------------------------------
// Distance keeping drive control: tick tracker
// Keeps sample age and stale phase counters and registers one tick decision.
// ----------------------------------------------------------------------------
`default_nettype none

module dkdc_tracker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dkdc_pkg::cfg_t              cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        sample_valid,
    input  wire logic [dkdc_pkg::DIST_W-1:0] distance_in,
    input  wire logic                        tick_take,
    output logic                             tick_valid,
    output dkdc_pkg::tick_t                  tick
);
    import dkdc_pkg::*;

    logic              seen_reg, seen_next;
    logic [DIST_W-1:0] last_reg, last_next;
    logic [TICK_W-1:0] age_reg, age_next;
    logic              to_reg, to_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              valid_reg, valid_next;
    tick_t             tick_reg, tick_next;
    logic              accept;

    // Free the stage when empty or when the drive stage takes its tick
    assign in_ready = !valid_reg || tick_take;
    assign accept   = in_valid && in_ready;

    // Advance the sample age and stale phase for one tick
    always_comb
    begin
        seen_next    = seen_reg;
        last_next    = last_reg;
        age_next     = age_reg;
        to_next      = to_reg;
        elapsed_next = elapsed_reg;
        tick_next    = tick_reg;
        valid_next   = tick_take ? 1'b0 : valid_reg;
        if (accept)
        begin
            if (sample_valid)
            begin
                seen_next = 1'b1;
                last_next = distance_in;
                age_next  = '0;
            end
            else if (seen_reg)
            begin
                age_next = (age_reg == '1) ? age_reg : age_reg + 1'b1;
            end
            valid_next         = seen_next;
            tick_next.distance = last_next;
            tick_next.kind     = KIND_FRESH;
            if (seen_next)
            begin
                if (age_next < cfg.timeout_ticks)
                begin
                    to_next      = 1'b0;
                    elapsed_next = '0;
                end
                else
                begin
                    if (!to_reg)
                    begin
                        to_next      = 1'b1;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        elapsed_next = (elapsed_reg == '1) ? elapsed_reg
                                                           : elapsed_reg + 1'b1;
                    end
                    tick_next.kind = (elapsed_next < cfg.stop_ticks) ? KIND_STOP
                                                                     : KIND_SEARCH;
                end
            end
        end
    end

    // Hold tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            last_reg    <= '0;
            age_reg     <= '0;
            to_reg      <= 1'b0;
            elapsed_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            seen_reg    <= seen_next;
            last_reg    <= last_next;
            age_reg     <= age_next;
            to_reg      <= to_next;
            elapsed_reg <= elapsed_next;
            valid_reg   <= valid_next;
        end
    end

    // Tick record payload
    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
    end

    assign tick_valid = valid_reg;
    assign tick       = tick_reg;

endmodule

`default_nettype wire

// ===== hdl/dkdc_drive.sv =====
// ----------------------------------------------------------------------------
// Distance keeping drive control: drive stage
// Turns one tick decision into duty, direction and mode; holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "distance_keeping_drive_control_top_defines.svh"

module dkdc_drive (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dkdc_pkg::cfg_t     cfg,
    input  wire logic               tick_valid,
    input  wire dkdc_pkg::tick_t    tick,
    output logic                    tick_take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    standby_n,
    output logic [1:0]              direction,
    output logic [dkdc_pkg::DUTY_W-1:0] duty,
    output dkdc_pkg::mode_t         drive_mode,
    output logic [31:0]             drive_word
);
    import dkdc_pkg::*;

    logic              valid_reg;
    logic              stby_reg, stby_next;
    logic [1:0]        dir_reg, dir_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    mode_t             mode_reg, mode_next;

    logic              in_zone;
    logic [DIST_W-1:0] mag;
    logic [23:0]       prod;
    logic [19:0]       scaled;
    logic [DUTY_W-1:0] span;
    logic [DUTY_W-1:0] boost;

    // Take a tick when the result register is empty or drains this cycle
    assign tick_take = tick_valid && (!valid_reg || out_ready);

    // Proportional duty: floor plus rounded, span-limited error times gain
    always_comb
    begin
        in_zone = (tick.distance >= cfg.dz_low) && (tick.distance <= cfg.dz_high);
        mag     = (tick.distance >= cfg.target) ? tick.distance - cfg.target
                                                : cfg.target - tick.distance;
        prod    = {8'b0, mag} * {16'b0, cfg.gain};
        scaled  = 20'((prod + ROUND_HALF) >> 4);
        span    = (cfg.duty_ceiling > cfg.duty_floor) ? cfg.duty_ceiling - cfg.duty_floor
                                                      : '0;
        boost   = (scaled < {12'b0, span}) ? scaled[DUTY_W-1:0] : span;
    end

    // Select outputs by tick kind
    always_comb
    begin
        stby_next = 1'b0;
        dir_next  = DIR_STOP;
        duty_next = '0;
        mode_next = MODE_TIMEOUT;
        unique case (tick.kind)
            KIND_FRESH:
            begin
                if (in_zone)
                begin
                    mode_next = MODE_HOLD;
                end
                else
                begin
                    stby_next = 1'b1;
                    dir_next  = (tick.distance < cfg.target) ? DIR_FWD : DIR_BWD;
                    duty_next = cfg.duty_floor + boost;
                    mode_next = MODE_MOVE;
                end
            end
            KIND_SEARCH:
            begin
                stby_next = 1'b1;
                dir_next  = DIR_BWD;
                duty_next = cfg.duty_ceiling;
                mode_next = MODE_SEARCH;
            end
            default:
            begin
                mode_next = MODE_TIMEOUT;
            end
        endcase
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (tick_take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each taken tick
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            stby_reg <= stby_next;
            dir_reg  <= dir_next;
            duty_reg <= duty_next;
            mode_reg <= mode_next;
        end
    end

    assign out_valid  = valid_reg;
    assign standby_n  = stby_reg;
    assign direction  = dir_reg;
    assign duty       = duty_reg;
    assign drive_mode = mode_reg;
    assign drive_word = {stby_reg, dir_reg, duty_reg, 11'b0, duty_reg, dir_reg};

    // Checks
    `DKDC_ASSERT_IMP(a_move_drives, out_valid && (drive_mode == MODE_MOVE),
        standby_n && ((direction == DIR_FWD) || (direction == DIR_BWD)),
        "proportional result without drive")
    `DKDC_ASSERT_IMP(a_stop_quiet, out_valid && !standby_n,
        (direction == DIR_STOP) && (duty == '0),
        "stopped result carries drive fields")
    `DKDC_ASSERT_NXT(a_search_duty, tick_take && (tick.kind == KIND_SEARCH),
        out_valid && (drive_mode == MODE_SEARCH) && (duty == cfg.duty_ceiling),
        "search tick not delivered at ceiling duty")

endmodule

`default_nettype wire

// ===== hdl/distance_keeping_drive_control_top.sv =====
// ----------------------------------------------------------------------------
// Distance keeping drive control: top level
// Motor drive controller that holds a set distance from a range sensor.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one control tick per transfer: tuser flags a fresh
//   distance sample, tdata holds the distance. m_axis returns one drive
//   command per tick once the first sample has arrived; earlier ticks give
//   no transfer. cfg_wr_en/cfg_index/cfg_wdata write the eight setup
//   registers; the user must write them only while the block is idle, as
//   the block itself does not enforce this. A result reaches m_axis
//   through the tick register, then the result register. The block takes
//   one tick per cycle while m_axis does not stall. When m_axis stalls, the
//   result register holds and one more tick waits in the tick register;
//   s_axis_tready drops only when both are full.
//   Reset clears counters and valid flags and loads the default setpoint,
//   dead zone, duty limits, gain and tick limits.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_keeping_drive_control_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [dkdc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [dkdc_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [15:0]                s_axis_tdata,  // [15:0] distance_in
    input  wire logic                       s_axis_tuser,  // [0] sample_valid
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [0] standby_n, [2:1] direction, [10:3] duty, [42:11] drive_word, [47:43] zero
    output logic [dkdc_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic [1:0]                      m_axis_tuser   // [1:0] drive_mode
);
    import dkdc_pkg::*;

    cfg_t              cfg;
    tick_t             tick;
    logic              tick_valid;
    logic              tick_take;
    logic              standby_n;
    logic [1:0]        direction;
    logic [DUTY_W-1:0] duty;
    mode_t             drive_mode;
    logic [31:0]       drive_word;

    // Setup registers
    dkdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Tick tracking and decision register
    dkdc_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .sample_valid (s_axis_tuser),
        .distance_in  (s_axis_tdata),
        .tick_take    (tick_take),
        .tick_valid   (tick_valid),
        .tick         (tick)
    );

    // Duty computation and result register
    dkdc_drive u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick_valid (tick_valid),
        .tick       (tick),
        .tick_take  (tick_take),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .standby_n  (standby_n),
        .direction  (direction),
        .duty       (duty),
        .drive_mode (drive_mode),
        .drive_word (drive_word)
    );

    // Pack the result transfer
    assign m_axis_tdata = {5'b0, drive_word, duty, direction, standby_n};
    assign m_axis_tuser = drive_mode;

endmodule

`default_nettype wire
